>>> sv/mce_pkg.sv
// Shared types, constants and helper functions for the motor command encoder.
`default_nettype none
package mce_pkg;

	localparam int LimW   = 26;
	localparam int ValW   = 32;
	localparam int SpanW  = LimW + 1;
	localparam int CodeW  = 16;
	localparam int NumW   = SpanW + CodeW;
	localparam int Lanes  = 5;
	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int Steps  = CodeW;
	localparam int CfgIdxW = 3;
	localparam int CfgW   = LimW;

	// Lane order: position, velocity, stiffness, damping, torque.
	localparam logic [Lanes-1:0] LaneSym  = 5'b10011;
	localparam logic [Lanes-1:0] LaneWide = 5'b00001;

	typedef enum logic [1:0] {
		OP_SETPOINT = 2'd0,
		OP_ENABLE   = 2'd1,
		OP_DISABLE  = 2'd2,
		OP_SPARE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_SET = 2'd0,
		KIND_EN  = 2'd1,
		KIND_DIS = 2'd2
	} kind_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_POS_LIM  = 3'd0,
		REG_VEL_LIM  = 3'd1,
		REG_TRQ_LIM  = 3'd2,
		REG_STF_LIM  = 3'd3,
		REG_DMP_LIM  = 3'd4,
		REG_EN_TAIL  = 3'd5,
		REG_DIS_TAIL = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [Lanes-1:0][LimW-1:0] lim;
		logic [7:0]                 en_tail;
		logic [7:0]                 dis_tail;
	} cfg_t;

	typedef struct packed {
		kind_t                      kind;
		logic [Lanes-1:0]           mask;
		logic [Lanes-1:0][NumW-1:0] num;
	} front_item_t;

	typedef struct packed {
		kind_t                       kind;
		logic [Lanes-1:0]            mask;
		logic [Lanes-1:0][SpanW-1:0] rem;
		logic [Lanes-1:0][CodeW-1:0] low;
		logic [Lanes-1:0][CodeW-1:0] quo;
	} div_stage_t;

	typedef struct packed {
		logic             hit;
		logic [SpanW-1:0] x;
	} prep_t;

	// Width of the range of one lane: twice the limit when symmetric about zero.
	function automatic logic [SpanW-1:0] lane_span(input logic [LimW-1:0] lim, input logic sym);
		lane_span = sym ? {lim, 1'b0} : {1'b0, lim};
	endfunction

	// Clamp a value to its range and return its offset from the bottom of the range.
	function automatic prep_t lane_prep(input logic signed [ValW-1:0] v,
			input logic [LimW-1:0] lim, input logic sym);
		logic signed [ValW+1:0] v34;
		logic signed [ValW+1:0] lo;
		logic signed [ValW+1:0] hi;
		logic signed [ValW+1:0] c;
		logic signed [ValW+1:0] d;
		v34 = {{2{v[ValW-1]}}, v};
		hi = $signed({8'd0, lim});
		lo = sym ? -hi : '0;
		c = v34;
		lane_prep.hit = 1'b0;
		if (v34 < lo) begin
			c = lo;
			lane_prep.hit = 1'b1;
		end
		if (v34 > hi) begin
			c = hi;
			lane_prep.hit = 1'b1;
		end
		d = c - lo;
		lane_prep.x = d[SpanW-1:0];
	endfunction

endpackage
`default_nettype wire

>>> sv/mce_if.sv
// Handshake interfaces for the command input and the frame output channels.
`default_nettype none
interface mce_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic signed [31:0] position;
	logic signed [31:0] velocity;
	logic signed [31:0] gain_stiffness;
	logic signed [31:0] gain_damping;
	logic signed [31:0] torque_ff;

	modport source(output valid, operation, position, velocity, gain_stiffness,
		gain_damping, torque_ff, input ready);
	modport sink(input valid, operation, position, velocity, gain_stiffness,
		gain_damping, torque_ff, output ready);
endinterface

interface mce_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte_0;
	logic [7:0] frame_byte_1;
	logic [7:0] frame_byte_2;
	logic [7:0] frame_byte_3;
	logic [7:0] frame_byte_4;
	logic [7:0] frame_byte_5;
	logic [7:0] frame_byte_6;
	logic [7:0] frame_byte_7;
	logic [4:0] clamped_mask;

	modport source(output valid, frame_byte_0, frame_byte_1, frame_byte_2, frame_byte_3,
		frame_byte_4, frame_byte_5, frame_byte_6, frame_byte_7, clamped_mask, input ready);
	modport sink(input valid, frame_byte_0, frame_byte_1, frame_byte_2, frame_byte_3,
		frame_byte_4, frame_byte_5, frame_byte_6, frame_byte_7, clamped_mask, output ready);
endinterface
`default_nettype wire

>>> sv/mce_front.sv
// Front end: accepts commands, classifies them, clamps and scales the set-point values.
`default_nettype none
module mce_front import mce_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	mce_cmd_if.sink      cmd,
	input  wire cfg_t    cfg,
	output front_item_t  item,
	output logic         item_valid,
	input  wire logic    item_ready
);

	front_item_t item_s1;
	logic        vld_s1;
	front_item_t nxt;
	logic [Lanes-1:0][ValW-1:0] vals;

	assign cmd.ready  = !vld_s1 || item_ready;
	assign item       = item_s1;
	assign item_valid = vld_s1;

	assign vals = {cmd.torque_ff, cmd.gain_damping, cmd.gain_stiffness,
		cmd.velocity, cmd.position};

	// Classify the command and build the numerators of the five scaling divisions.
	always_comb begin
		prep_t            p;
		logic [CodeW-1:0] top;
		nxt = '0;
		case (op_t'(cmd.operation))
			OP_ENABLE:  nxt.kind = KIND_EN;
			OP_DISABLE: nxt.kind = KIND_DIS;
			default:    nxt.kind = KIND_SET;
		endcase
		for (int l = 0; l < Lanes; l++) begin
			p = lane_prep(vals[l], cfg.lim[l], LaneSym[l]);
			top = LaneWide[l] ? 16'hFFFF : 16'h0FFF;
			nxt.mask[l] = p.hit && (nxt.kind == KIND_SET);
			nxt.num[l] = NumW'(p.x) * NumW'(top);
		end
	end

	// Stage register; it holds while the queue is full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			vld_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1 <= nxt;
		end
	end

endmodule
`default_nettype wire

>>> sv/mce_fifo.sv
// Short queue that decouples the front end from the division pipeline.
`default_nettype none
module mce_fifo import mce_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire front_item_t  push_data,
	output logic              full,
	input  wire logic         pop,
	output front_item_t       pop_data,
	output logic              not_empty
);

	front_item_t          mem_q [QDepth];
	logic [QPtrW-1:0]     wr_q;
	logic [QPtrW-1:0]     rd_q;
	logic [QPtrW:0]       cnt_q;

	assign full      = (cnt_q == (QPtrW+1)'(QDepth));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem_q[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

>>> sv/mce_back.sv
// Back end: restoring division pipeline, one quotient bit per stage, and frame packing.
`default_nettype none
module mce_back import mce_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire cfg_t         cfg,
	input  wire front_item_t  item,
	input  wire logic         item_valid,
	output logic              pop,
	mce_frame_if.source       frame
);

	div_stage_t div_s [Steps+1];
	logic [Steps:0] vld_s;
	logic           out_vld_q;
	logic           adv;
	logic [Lanes-1:0][SpanW-1:0] dvs;

	// The whole pipeline moves unless a finished frame waits for the receiver.
	assign adv   = !out_vld_q || frame.ready;
	assign pop   = adv && item_valid;
	assign frame.valid = out_vld_q;

	always_comb begin
		for (int l = 0; l < Lanes; l++) begin
			dvs[l] = lane_span(cfg.lim[l], LaneSym[l]);
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s     <= {vld_s[Steps-1:0], item_valid};
			out_vld_q <= vld_s[Steps];
		end
	end

	// Load: the upper numerator bits form the first partial remainder.
	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0].kind <= item.kind;
			div_s[0].mask <= item.mask;
			for (int l = 0; l < Lanes; l++) begin
				div_s[0].rem[l] <= item.num[l][NumW-1:CodeW];
				div_s[0].low[l] <= item.num[l][CodeW-1:0];
				div_s[0].quo[l] <= '0;
			end
		end
	end

	// One quotient bit per stage for every lane.
	for (genvar k = 0; k < Steps; k++) begin : g_step
		div_stage_t nxt;

		always_comb begin
			logic [SpanW:0] rr;
			nxt = div_s[k];
			for (int l = 0; l < Lanes; l++) begin
				rr = {div_s[k].rem[l], div_s[k].low[l][CodeW-1]};
				nxt.low[l] = {div_s[k].low[l][CodeW-2:0], 1'b0};
				if (rr >= {1'b0, dvs[l]}) begin
					nxt.rem[l] = SpanW'(rr - {1'b0, dvs[l]});
					nxt.quo[l] = {div_s[k].quo[l][CodeW-2:0], 1'b1};
				end else begin
					nxt.rem[l] = rr[SpanW-1:0];
					nxt.quo[l] = {div_s[k].quo[l][CodeW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[k+1] <= nxt;
			end
		end
	end

	// Pack the codes into the frame, or build an enable or disable frame.
	always_ff @(posedge clk) begin
		logic [Lanes-1:0][CodeW-1:0] code;
		for (int l = 0; l < Lanes; l++) begin
			code[l] = (dvs[l] == '0) ? '0 : div_s[Steps].quo[l];
		end
		if (adv) begin
			if (div_s[Steps].kind == KIND_SET) begin
				frame.frame_byte_0 <= code[0][15:8];
				frame.frame_byte_1 <= code[0][7:0];
				frame.frame_byte_2 <= code[1][11:4];
				frame.frame_byte_3 <= {code[1][3:0], code[2][11:8]};
				frame.frame_byte_4 <= code[2][7:0];
				frame.frame_byte_5 <= code[3][11:4];
				frame.frame_byte_6 <= {code[3][3:0], code[4][11:8]};
				frame.frame_byte_7 <= code[4][7:0];
			end else begin
				frame.frame_byte_0 <= 8'hFF;
				frame.frame_byte_1 <= 8'hFF;
				frame.frame_byte_2 <= 8'hFF;
				frame.frame_byte_3 <= 8'hFF;
				frame.frame_byte_4 <= 8'hFF;
				frame.frame_byte_5 <= 8'hFF;
				frame.frame_byte_6 <= 8'hFF;
				frame.frame_byte_7 <= (div_s[Steps].kind == KIND_EN) ? cfg.en_tail
					: cfg.dis_tail;
			end
			frame.clamped_mask <= div_s[Steps].mask;
		end
	end

endmodule
`default_nettype wire

>>> sv/mit_motor_command_encoder_core.sv
// Top level of the MIT-mode motor command frame encoder.
//
// Commands arrive on the cmd channel (valid/ready) and each gives exactly one
// 8-byte frame with a clamp mask on the frame channel, in order.
// Limits and tail bytes are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while the block is idle, which the block does not enforce.
// Writes to an index past the last register are ignored. A new command can be
// taken in every cycle while the front-end stage or the queue has room. The front
// end clamps and scales in one stage, a four-entry queue follows, then a 16-stage
// restoring divider yields one quotient bit per stage and the packing stage
// registers the frame. Throughput is one frame per cycle, set by the divider
// pipeline, while the receiver keeps ready high. When the receiver holds ready low
// the frame stays on the outputs, the divider pipeline holds, the queue fills and then cmd.ready drops.
// Reset clears all valid state and loads the default limits and tail bytes.
`default_nettype none
module mit_motor_command_encoder_core import mce_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	mce_cmd_if.sink                 cmd,
	mce_frame_if.source             frame,
	input  wire logic               cfg_we,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [CfgW-1:0]    cfg_data
);

	cfg_t        cfg_q;
	front_item_t f_item;
	logic        f_valid;
	logic        q_full;
	front_item_t q_item;
	logic        q_valid;
	logic        q_pop;

	// Configuration registers. Lane order: position, velocity, stiffness, damping, torque.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lim[0]    <= 26'd819200;
			cfg_q.lim[1]    <= 26'd1638400;
			cfg_q.lim[2]    <= 26'd32768000;
			cfg_q.lim[3]    <= 26'd327680;
			cfg_q.lim[4]    <= 26'd655360;
			cfg_q.en_tail   <= 8'd252;
			cfg_q.dis_tail  <= 8'd253;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_POS_LIM:  cfg_q.lim[0]   <= cfg_data;
				REG_VEL_LIM:  cfg_q.lim[1]   <= cfg_data;
				REG_TRQ_LIM:  cfg_q.lim[4]   <= cfg_data;
				REG_STF_LIM:  cfg_q.lim[2]   <= cfg_data;
				REG_DMP_LIM:  cfg_q.lim[3]   <= cfg_data;
				REG_EN_TAIL:  cfg_q.en_tail  <= cfg_data[7:0];
				REG_DIS_TAIL: cfg_q.dis_tail <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	mce_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg_q),
		.item       (f_item),
		.item_valid (f_valid),
		.item_ready (!q_full)
	);

	mce_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_valid && !q_full),
		.push_data (f_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_item),
		.not_empty (q_valid)
	);

	mce_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item       (q_item),
		.item_valid (q_valid),
		.pop        (q_pop),
		.frame      (frame)
	);

endmodule
`default_nettype wire

>>> sv/mce_checker.sv
// Port-level checks of the encoder, bound to the top level.
`default_nettype none
module mce_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       frame_valid,
	input wire logic       frame_ready,
	input wire logic [7:0] b0,
	input wire logic [7:0] b1,
	input wire logic [7:0] b6,
	input wire logic [7:0] b7,
	input wire logic [4:0] mask
);

	// A frame that is not taken stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && !frame_ready |=> frame_valid)
		else $error("frame dropped while stalled");

	// A clamped position sits at one end of the code range.
	a_pos_end: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && mask[0] |-> ({b0, b1} == 16'h0000 || {b0, b1} == 16'hFFFF))
		else $error("clamped position code not at range end");

	// A clamped torque sits at one end of the code range.
	a_trq_end: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && mask[4] |-> ({b6[3:0], b7} == 12'h000 || {b6[3:0], b7} == 12'hFFF))
		else $error("clamped torque code not at range end");

	// A stalled frame keeps its contents until it is taken.
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && !frame_ready |=> $stable({b0, b1, b6, b7, mask}))
		else $error("frame contents changed while stalled");

endmodule

bind mit_motor_command_encoder_core mce_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.frame_valid (frame.valid),
	.frame_ready (frame.ready),
	.b0          (frame.frame_byte_0),
	.b1          (frame.frame_byte_1),
	.b6          (frame.frame_byte_6),
	.b7          (frame.frame_byte_7),
	.mask        (frame.clamped_mask)
);
`default_nettype wire
